// File: rtl/mst_pkg.sv
// Shared types and constants of the MessagePack stream tokenizer.
package mst_pkg;

    localparam int NestDepth = 16;
    localparam int LvlW      = 5;
    localparam int IdxW      = 4;
    localparam int CntW      = 33;

    typedef enum logic [3:0] {
        EV_NIL     = 4'd0,
        EV_FALSE   = 4'd1,
        EV_TRUE    = 4'd2,
        EV_UINT    = 4'd3,
        EV_SINT    = 4'd4,
        EV_F32     = 4'd5,
        EV_F64     = 4'd6,
        EV_STR     = 4'd7,
        EV_BIN     = 4'd8,
        EV_PAYLOAD = 4'd9,
        EV_ARRAY   = 4'd10,
        EV_MAP     = 4'd11,
        EV_EXT     = 4'd12,
        EV_END     = 4'd13,
        EV_ERROR   = 4'd14
    } t_event;

    typedef enum logic [2:0] {
        PH_TYPE, PH_FIELD, PH_PAYLOAD, PH_EXT_TAG, PH_EXT_DATA
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_EMIT, S_POP_RD, S_POP_CHK
    } t_state;

endpackage

// File: rtl/mst_ram.sv
// Generic single-port write, single-port read RAM with registered read data.
module mst_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/msgpack_stream_tokenizer.sv
// Top level of the MessagePack stream tokenizer.
// One item (byte) is accepted in S_IDLE and decoded in S_DECODE, then each event is offered in S_EMIT.
// An item finishing inside a container, and each closed container with a parent, first
// passes S_POP_RD and S_POP_CHK, which read and update the child count in the stack RAM.
// Synchronous active-low reset returns the decoder to awaiting a type byte at level 0,
// clears the error latch and sets max_nesting to 16; the stack RAM is not cleared.
module msgpack_stream_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_event_kind,
    output logic [63:0] o_value,
    output logic [4:0]  o_nesting_level,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata
);
    import mst_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [7:0]  r_byte, r_type, n_type;
    logic [3:0]  r_fleft, n_fleft;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_pleft, n_pleft;
    logic [LvlW-1:0] r_lvl, n_lvl;
    logic r_err, n_err;
    logic [4:0] r_maxn;

    // Pending event and follow-up actions.
    t_event r_ev, n_ev;
    logic [63:0] r_val, n_val;
    logic [LvlW-1:0] r_evl, n_evl;
    logic r_close, n_close;  // the innermost container closes after this event
    logic r_end2, n_end2;    // empty container: an end event follows

    logic ram_we;
    logic [IdxW-1:0] ram_waddr, ram_raddr;
    logic [CntW-1:0] ram_wdata, ram_rdata;

    mst_ram #(.Width(CntW), .Depth(NestDepth)) u_stack (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    logic [LvlW-1:0] lim;
    assign lim = (r_maxn > LvlW'(NestDepth)) ? LvlW'(NestDepth) : r_maxn;

    logic [CntW-1:0] dec_cnt;
    assign dec_cnt = ram_rdata - CntW'(1);
    assign ram_raddr = IdxW'(r_lvl - LvlW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_TYPE;
            r_type  <= '0;
            r_fleft <= '0;
            r_acc   <= '0;
            r_pleft <= '0;
            r_lvl   <= '0;
            r_err   <= 1'b0;
            r_maxn  <= 5'd16;
            r_close <= 1'b0;
            r_end2  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_type  <= n_type;
            r_fleft <= n_fleft;
            r_acc   <= n_acc;
            r_pleft <= n_pleft;
            r_lvl   <= n_lvl;
            r_err   <= n_err;
            r_close <= n_close;
            r_end2  <= n_end2;
            if (i_cfg_we) begin
                r_maxn <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_data_byte;
        end
        r_ev  <= n_ev;
        r_val <= n_val;
        r_evl <= n_evl;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_EMIT);
    assign o_event_kind    = r_ev;
    assign o_value         = r_val;
    assign o_nesting_level = r_evl;
    // The child count is settled before an event goes out, so the last event is known.
    assign o_last_of_run   = !r_end2 && !r_close;

    always_comb begin
        logic [7:0]  b;
        logic [63:0] v, acc8;
        logic        emit, fin, opn, isMap;
        logic [63:0] cnt;
        b = r_byte;
        n_state = r_state;
        n_phase = r_phase;
        n_type  = r_type;
        n_fleft = r_fleft;
        n_acc   = r_acc;
        n_pleft = r_pleft;
        n_lvl   = r_lvl;
        n_err   = r_err;
        n_ev    = r_ev;
        n_val   = r_val;
        n_evl   = r_evl;
        n_close = r_close;
        n_end2  = r_end2;
        ram_we  = 1'b0;
        ram_waddr = IdxW'(r_lvl);
        ram_wdata = '0;
        emit = 1'b0;
        fin  = 1'b0;
        opn  = 1'b0;
        isMap = 1'b0;
        cnt  = '0;
        v    = '0;
        acc8 = {r_acc[55:0], b};

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                n_end2  = 1'b0;
                if (r_err) begin
                    n_ev = EV_ERROR; v = '0; emit = 1'b1;
                end else begin
                    case (r_phase)
                        PH_FIELD: begin
                            n_acc = acc8;
                            if (r_fleft <= 4'd1) begin
                                n_fleft = '0;
                                n_phase = PH_TYPE;
                                if (r_type == 8'hca) begin
                                    n_ev = EV_F32; v = acc8; emit = 1'b1; fin = 1'b1;
                                end else if (r_type == 8'hcb) begin
                                    n_ev = EV_F64; v = acc8; emit = 1'b1; fin = 1'b1;
                                end else if (r_type inside {[8'hcc:8'hcf]}) begin
                                    n_ev = EV_UINT; v = acc8; emit = 1'b1; fin = 1'b1;
                                end else if (r_type inside {[8'hd0:8'hd3]}) begin
                                    v = acc8;
                                    case (r_type[1:0])
                                        2'd0: v = {{56{acc8[7]}}, acc8[7:0]};
                                        2'd1: v = {{48{acc8[15]}}, acc8[15:0]};
                                        2'd2: v = {{32{acc8[31]}}, acc8[31:0]};
                                        default: v = acc8;
                                    endcase
                                    n_ev = EV_SINT; emit = 1'b1; fin = 1'b1;
                                end else if (r_type inside {[8'hd9:8'hdb], [8'hc4:8'hc6]}) begin
                                    n_ev = (r_type >= 8'hd9) ? EV_STR : EV_BIN;
                                    v = acc8; emit = 1'b1;
                                    if (acc8 == '0) fin = 1'b1;
                                    else begin
                                        n_pleft = acc8[31:0]; n_phase = PH_PAYLOAD;
                                    end
                                end else if (r_type inside {[8'hc7:8'hc9]}) begin
                                    n_pleft = acc8[31:0]; n_phase = PH_EXT_TAG;
                                end else if (r_type inside {[8'hdc:8'hdf]}) begin
                                    opn = 1'b1; isMap = r_type[1]; cnt = acc8;
                                end
                            end else begin
                                n_fleft = r_fleft - 4'd1;
                            end
                        end
                        PH_PAYLOAD: begin
                            n_ev = EV_PAYLOAD; v = {56'd0, b}; emit = 1'b1;
                            n_pleft = r_pleft - 32'd1;
                            if (r_pleft <= 32'd1) begin
                                n_pleft = '0; fin = 1'b1; n_phase = PH_TYPE;
                            end
                        end
                        PH_EXT_TAG: begin
                            if (r_pleft == '0) begin
                                n_ev = EV_EXT; v = r_acc; emit = 1'b1; fin = 1'b1;
                                n_phase = PH_TYPE;
                            end else begin
                                n_phase = PH_EXT_DATA;
                            end
                        end
                        PH_EXT_DATA: begin
                            n_pleft = r_pleft - 32'd1;
                            if (r_pleft <= 32'd1) begin
                                n_pleft = '0;
                                n_ev = EV_EXT; v = r_acc; emit = 1'b1; fin = 1'b1;
                                n_phase = PH_TYPE;
                            end
                        end
                        default: begin
                            n_type = b;
                            if (b <= 8'h7f) begin
                                n_ev = EV_UINT; v = {56'd0, b}; emit = 1'b1; fin = 1'b1;
                            end else if (b >= 8'he0) begin
                                n_ev = EV_SINT; v = {{56{1'b1}}, b}; emit = 1'b1; fin = 1'b1;
                            end else if (b[7:5] == 3'b101) begin
                                n_ev = EV_STR; v = {59'd0, b[4:0]}; emit = 1'b1;
                                if (b[4:0] == '0) fin = 1'b1;
                                else begin
                                    n_pleft = {27'd0, b[4:0]}; n_phase = PH_PAYLOAD;
                                end
                            end else if (b[7:5] == 3'b100) begin
                                opn = 1'b1; isMap = !b[4]; cnt = {60'd0, b[3:0]};
                            end else if (b == 8'hc0) begin
                                n_ev = EV_NIL; v = '0; emit = 1'b1; fin = 1'b1;
                            end else if (b == 8'hc2) begin
                                n_ev = EV_FALSE; v = '0; emit = 1'b1; fin = 1'b1;
                            end else if (b == 8'hc3) begin
                                n_ev = EV_TRUE; v = '0; emit = 1'b1; fin = 1'b1;
                            end else if (b == 8'hc1) begin
                                n_ev = EV_ERROR; v = {56'd0, b}; emit = 1'b1; n_err = 1'b1;
                            end else if (b inside {[8'hd4:8'hd8]}) begin
                                n_acc = 64'd1 << (b - 8'hd4);
                                n_pleft = 32'd1 << (b - 8'hd4);
                                n_phase = PH_EXT_TAG;
                            end else begin
                                n_acc = '0;
                                n_phase = PH_FIELD;
                                if (b == 8'hca) n_fleft = 4'd4;
                                else if (b == 8'hcb) n_fleft = 4'd8;
                                else if (b inside {[8'hcc:8'hd3]}) n_fleft = 4'd1 << b[1:0];
                                else if (b inside {[8'hd9:8'hdb]}) n_fleft = 4'd1 << (b - 8'hd9);
                                else if (b inside {[8'hc4:8'hc6]}) n_fleft = 4'd1 << (b - 8'hc4);
                                else if (b inside {[8'hc7:8'hc9]}) n_fleft = 4'd1 << (b - 8'hc7);
                                else n_fleft = 4'd2 << b[0];
                            end
                        end
                    endcase
                    if (opn) begin
                        if (r_lvl >= lim) begin
                            n_ev = EV_ERROR; v = {56'd0, n_type}; emit = 1'b1;
                            n_err = 1'b1; n_phase = PH_TYPE;
                        end else begin
                            n_ev = isMap ? EV_MAP : EV_ARRAY; v = cnt; emit = 1'b1;
                            n_phase = PH_TYPE;
                            if (cnt == '0) begin
                                n_end2 = 1'b1; fin = 1'b1;
                            end else begin
                                ram_we = 1'b1;
                                ram_wdata = isMap ? {cnt[31:0], 1'b0} : {1'b0, cnt[31:0]};
                                n_lvl = r_lvl + LvlW'(1);
                            end
                        end
                    end
                end
                n_val = v;
                n_evl = r_lvl;
                n_close = 1'b0;
                if (emit) begin
                    // A finished item inside a container updates the count before it goes out.
                    n_state = (fin && r_lvl != '0) ? S_POP_RD : S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_ready) begin
                    if (r_end2) begin
                        n_end2 = 1'b0;
                        n_ev = EV_END; n_val = '0; n_evl = r_lvl;
                    end else if (r_close) begin
                        n_close = 1'b0;
                        n_lvl = r_lvl - LvlW'(1);
                        n_ev = EV_END; n_val = '0; n_evl = r_lvl - LvlW'(1);
                        if (r_lvl != LvlW'(1)) begin
                            n_state = S_POP_RD;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_POP_RD: begin
                n_state = S_POP_CHK;
            end
            S_POP_CHK: begin
                // Count down the innermost open container; it closes at zero.
                ram_we = 1'b1;
                ram_waddr = IdxW'(r_lvl - LvlW'(1));
                ram_wdata = dec_cnt;
                n_close = (dec_cnt == '0);
                n_state = S_EMIT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Checks on the stack level, the error latch and the handshake.
    a_lvl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl <= LvlW'(NestDepth)) else $error("nesting level beyond stack");
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err) else $error("error latch cleared");
    a_err_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_err && $past(r_err)) |-> o_event_kind == EV_ERROR)
        else $error("non-error event while latched");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken while emitting");
endmodule
